>>> sv/aht_pkg.sv
// Shared types and constants of the averaging hysteresis thermostat.
package aht_pkg;

  // Operating mode as it appears on the result stream.
  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_ON  = 2'd1,
    MODE_SET = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MIN_SP  = 3'd0,
    CFG_MAX_SP  = 3'd1,
    CFG_INIT_SP = 3'd2,
    CFG_STEP    = 3'd3,
    CFG_HYST    = 3'd4,
    CFG_BLINK   = 3'd5,
    CFG_TIMEOUT = 3'd6
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_BLINK_GO,
    S_BLINK_WAIT,
    S_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the accepted input item
    logic update;     // commit the pass's state update
    logic div_start;  // start the divider
    logic mean_cap;   // capture the ring mean
    logic phase_cap;  // capture the blink phase from the divider
    logic out_load;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 32;

  localparam int unsigned DIV_W = 16;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [7:0]  MIN_SP_RST  = 8'd35;
  localparam logic [7:0]  MAX_SP_RST  = 8'd75;
  localparam logic [7:0]  INIT_SP_RST = 8'd60;
  localparam logic [7:0]  STEP_RST    = 8'd5;
  localparam logic [7:0]  HYST_RST    = 8'd5;
  localparam logic [15:0] BLINK_RST   = 16'd5;
  localparam logic [15:0] TIMEOUT_RST = 16'd50;

endpackage

>>> sv/averaging_hysteresis_thermostat_unit.sv
// Top level of the averaging hysteresis thermostat.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   one pass: tick, sample, key levels
//   m_axis    out        m_axis_tvalid/m_axis_tready   one result per pass
//   cfg       in         cfg_we_i (always taken)       register index and write data
//
// A pass runs from transfer to result through the state update, the bit-serial divider that
// works out the blink phase (start, 16 steps, done) and the load of the output register.
// The ring mean comes from a constant reciprocal multiply.
// The next pass is taken in the cycle after the output register loads.
// A stalled result holds in that register; processing waits only to load it.
// Reset is asynchronous and active low; the sample ring needs no clearing pass.
module averaging_hysteresis_thermostat_unit #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] tick, [8:1] sample, [9] up_level, [10] down_level, [11] power_level
  input  logic [aht_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] mode, [2] heater_on, [3] cooler_on, [4] led_on, [5] display_on,
  // [13:6] display_value, [21:14] mean_temp, [29:22] setpoint
  output logic [aht_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [aht_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aht_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  aht_pkg::cmd_t  cmd;
  aht_pkg::stat_t stat;

  aht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  aht_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> sv/aht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module aht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/aht_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module aht_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [aht_pkg::DIV_W-1:0]  dividend_i,
  input  logic [aht_pkg::DIV_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [aht_pkg::DIV_W-1:0]  quot_o
);

  localparam int unsigned W = aht_pkg::DIV_W;

  logic [W-1:0]                   rem_q, rem_d;
  logic [W-1:0]                   quo_q, quo_d;
  logic [W-1:0]                   dvs_q;
  logic [aht_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [W:0]                     trial;
  logic [W:0]                     diff;
  logic                           ge;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = aht_pkg::DIV_CNT_W'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == aht_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> sv/aht_ctrl.sv
// Pass sequencer of the thermostat: accept, update, blink division, emit.
module aht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  aht_pkg::stat_t stat_i,
  output aht_pkg::cmd_t  cmd_o
);

  aht_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      aht_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = aht_pkg::S_UPDATE;
        end
      end
      aht_pkg::S_UPDATE:   state_d = aht_pkg::S_BLINK_GO;
      aht_pkg::S_BLINK_GO: state_d = aht_pkg::S_BLINK_WAIT;
      aht_pkg::S_BLINK_WAIT: begin
        if (stat_i.div_done) begin
          state_d = aht_pkg::S_EMIT;
        end
      end
      aht_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          state_d = aht_pkg::S_IDLE;
        end
      end
      default: state_d = aht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      aht_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      aht_pkg::S_UPDATE:    cmd_o.update = 1'b1;
      aht_pkg::S_BLINK_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.mean_cap  = 1'b1;
      end
      aht_pkg::S_BLINK_WAIT: cmd_o.phase_cap = stat_i.div_done;
      aht_pkg::S_EMIT:       cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aht_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/aht_dpath.sv
// Datapath of the thermostat: registers, sample ring, divider and result register.
module aht_dpath #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  aht_pkg::cmd_t                     cmd_i,
  output aht_pkg::stat_t                    stat_o,
  input  logic [aht_pkg::S_TDATA_W-1:0]     in_data_i,
  input  logic                              cfg_we_i,
  input  logic [aht_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [aht_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [aht_pkg::M_TDATA_W-1:0]     out_data_o
);

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SUM_W = 8 + IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  // The mean is the sum times a rounded-up reciprocal of the ring depth. With a shift of
  // SUM_W + IDX_W the quotient is exact for every sum that fits in SUM_W bits.
  localparam int unsigned RCP_SH = SUM_W + IDX_W;
  localparam int unsigned PROD_W = SUM_W + SUM_W + 2;
  localparam logic [SUM_W+1:0] RCP_M =
    (SUM_W+2)'(((1 << RCP_SH) + RING_DEPTH - 1) / RING_DEPTH);

  // Configuration registers.
  logic [7:0]  min_sp_q, max_sp_q, step_q, hyst_q;
  logic [15:0] blink_q, tmo_q;

  // Latched input item.
  logic        in_tick_q, in_up_q, in_down_q, in_power_q;
  logic [7:0]  in_sample_q;

  // Thermostat state.
  aht_pkg::mode_e          mode_q, mode_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [15:0]             tc_q, tc_d;
  logic [7:0]              sp_q, sp_d;
  logic                    ul_q, ul_d, dl_q, dl_d, ph_q;
  logic [RING_DEPTH-1:0]   valid_q;
  logic [7:0]              mean_q;
  logic                    phase_q;

  // Result register.
  logic                          out_valid_q;
  logic [aht_pkg::M_TDATA_W-1:0] out_data_q, out_data_d;

  logic [7:0]              ram_rdata, old_sample;
  aht_pkg::mode_e          m_cur;
  logic                    tk, clr, released;
  logic [15:0]             tc_tick;
  logic [8:0]              up_sum, dn_lim;
  logic                    up_ok, dn_ok;
  logic [7:0]              sp_a;
  logic                    ram_we;
  logic [PROD_W-1:0]       mean_prod;
  logic [7:0]              mean_rcp;

  logic [aht_pkg::DIV_W-1:0] div_dividend, div_divisor, div_quot;
  logic                      div_done;

  logic                    heat, cool, led, disp;
  logic [7:0]              dval;

  aht_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (in_sample_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // An entry not written since the ring was last cleared reads as zero.
  assign old_sample = valid_q[idx_q] ? ram_rdata : 8'd0;

  always_comb begin
    case (mode_q)
      aht_pkg::MODE_ON:  m_cur = aht_pkg::MODE_ON;
      aht_pkg::MODE_SET: m_cur = aht_pkg::MODE_SET;
      default:           m_cur = aht_pkg::MODE_OFF;
    endcase
  end

  assign tk      = in_tick_q && (m_cur != aht_pkg::MODE_OFF);
  assign tc_tick = tk ? (tc_q + 16'd1) : tc_q;
  assign ram_we  = cmd_i.update && tk;

  assign up_sum = {1'b0, sp_q} + {1'b0, step_q};
  assign up_ok  = in_up_q && !ul_q && (up_sum <= {1'b0, max_sp_q});
  assign sp_a   = up_ok ? up_sum[7:0] : sp_q;
  assign dn_lim = {1'b0, min_sp_q} + {1'b0, step_q};
  assign dn_ok  = in_down_q && !dl_q && ({1'b0, sp_a} >= dn_lim);

  assign released = ph_q && !in_power_q;

  always_comb begin
    mode_d = m_cur;
    tc_d   = tc_tick;
    sp_d   = sp_q;
    ul_d   = ul_q;
    dl_d   = dl_q;
    clr    = 1'b0;
    case (m_cur)
      aht_pkg::MODE_ON: begin
        // A fresh press only enters setting mode; the step comes on a later pass.
        if ((in_up_q && !ul_q) || (in_down_q && !dl_q)) begin
          tc_d   = '0;
          mode_d = aht_pkg::MODE_SET;
        end
      end
      aht_pkg::MODE_SET: begin
        if (up_ok) begin
          sp_d = sp_a;
          tc_d = '0;
          ul_d = 1'b1;
        end
        if (dn_ok) begin
          sp_d = sp_a - step_q;
          tc_d = '0;
          dl_d = 1'b1;
        end
        if (tc_d >= tmo_q) begin
          mode_d = aht_pkg::MODE_ON;
        end
      end
      default: ;
    endcase
    if (!in_up_q) begin
      ul_d = 1'b0;
    end
    if (!in_down_q) begin
      dl_d = 1'b0;
    end
    if (released) begin
      if (mode_d == aht_pkg::MODE_OFF) begin
        clr    = 1'b1;
        tc_d   = '0;
        mode_d = aht_pkg::MODE_ON;
      end else begin
        mode_d = aht_pkg::MODE_OFF;
      end
    end
  end

  always_comb begin
    if (clr) begin
      sum_d = '0;
      idx_d = '0;
    end else if (tk) begin
      sum_d = sum_q - SUM_W'(old_sample) + SUM_W'(in_sample_q);
      idx_d = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
    end else begin
      sum_d = sum_q;
      idx_d = idx_q;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sp_q <= aht_pkg::MIN_SP_RST;
      max_sp_q <= aht_pkg::MAX_SP_RST;
      step_q   <= aht_pkg::STEP_RST;
      hyst_q   <= aht_pkg::HYST_RST;
      blink_q  <= aht_pkg::BLINK_RST;
      tmo_q    <= aht_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aht_pkg::CFG_MIN_SP:  min_sp_q <= cfg_wdata_i[7:0];
        aht_pkg::CFG_MAX_SP:  max_sp_q <= cfg_wdata_i[7:0];
        aht_pkg::CFG_STEP:    step_q   <= cfg_wdata_i[7:0];
        aht_pkg::CFG_HYST:    hyst_q   <= cfg_wdata_i[7:0];
        aht_pkg::CFG_BLINK:   blink_q  <= cfg_wdata_i;
        aht_pkg::CFG_TIMEOUT: tmo_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The setpoint follows both the pass update and a write of the initial setpoint.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= aht_pkg::INIT_SP_RST;
    end else if (cfg_we_i && (cfg_idx_i == aht_pkg::CFG_INIT_SP)) begin
      sp_q <= cfg_wdata_i[7:0];
    end else if (cmd_i.update) begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= aht_pkg::MODE_OFF;
      idx_q   <= '0;
      sum_q   <= '0;
      tc_q    <= '0;
      ul_q    <= 1'b0;
      dl_q    <= 1'b0;
      ph_q    <= 1'b0;
      valid_q <= '0;
    end else if (cmd_i.update) begin
      mode_q <= mode_d;
      idx_q  <= idx_d;
      sum_q  <= sum_d;
      tc_q   <= tc_d;
      ul_q   <= ul_d;
      dl_q   <= dl_d;
      ph_q   <= in_power_q;
      if (clr) begin
        valid_q <= '0;
      end else if (tk) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  assign mean_prod = PROD_W'(sum_q) * PROD_W'(RCP_M);
  assign mean_rcp  = mean_prod[RCP_SH +: 8];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_tick_q   <= in_data_i[0];
      in_sample_q <= in_data_i[8:1];
      in_up_q     <= in_data_i[9];
      in_down_q   <= in_data_i[10];
      in_power_q  <= in_data_i[11];
    end
    if (cmd_i.mean_cap) begin
      mean_q <= mean_rcp;
    end
    if (cmd_i.phase_cap) begin
      phase_q <= div_quot[0];
    end
  end

  // The divider works out the blink phase: tick count over the blink period.
  assign div_dividend = tc_q;
  assign div_divisor  = (blink_q == '0) ? 16'd1 : blink_q;

  aht_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Band tests written without subtraction: mean + h < sp heats, mean > sp + h cools.
  always_comb begin
    heat = 1'b0;
    cool = 1'b0;
    led  = 1'b0;
    disp = 1'b0;
    dval = 8'd0;
    if (mode_q != aht_pkg::MODE_OFF) begin
      if (({1'b0, mean_q} + {1'b0, hyst_q}) < {1'b0, sp_q}) begin
        heat = 1'b1;
        led  = phase_q;
      end else if ({1'b0, mean_q} > ({1'b0, sp_q} + {1'b0, hyst_q})) begin
        cool = 1'b1;
        led  = 1'b1;
      end
      if (mode_q == aht_pkg::MODE_ON) begin
        disp = 1'b1;
        dval = mean_q;
      end else begin
        disp = phase_q;
        dval = sp_q;
      end
    end
    out_data_d = {2'b00, sp_q, mean_q, dval, disp, led, cool, heat, mode_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule

>>> sv/aht_checker.sv
// Port-level assertions for the thermostat and their bind to the top level.
module aht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [aht_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result keeps its place and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One pass at a time: the input side closes right after a transfer.
  a_one_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a pass is in progress");

  a_heat_cool_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[3]))
    else $error("heater and cooler both on");

  // With power off all drives and the display are dark.
  a_off_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == aht_pkg::MODE_OFF)
      |-> (m_axis_tdata[5:2] == 4'd0) && (m_axis_tdata[13:6] == 8'd0))
    else $error("outputs active in off mode");

  a_cool_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[4])
    else $error("LED dark while cooling");

endmodule

bind averaging_hysteresis_thermostat_unit aht_checker u_aht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> sim/averaging_hysteresis_thermostat_unit_test.sv
// Self-checking testbench of the averaging hysteresis thermostat with its own thermostat model.
module averaging_hysteresis_thermostat_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_LEN = 8;

  // One pass as it travels on s_axis_tdata, tick in bit 0.
  typedef struct packed {
    logic       power;
    logic       down;
    logic       up;
    logic [7:0] sample;
    logic       tick;
  } pass_t;

  // One result as it travels on m_axis_tdata, mode in the lowest bits.
  typedef struct packed {
    logic [7:0]     setpoint;
    logic [7:0]     mean;
    logic [7:0]     dval;
    logic           disp;
    logic           led;
    logic           cool;
    logic           heat;
    aht_pkg::mode_e mode;
  } reading_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [aht_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [aht_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic                           cfg_we_i = 1'b0;
  logic [aht_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [aht_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  averaging_hysteresis_thermostat_unit #(
    .RING_DEPTH(RING_LEN)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Settings as the block holds them.
  logic [7:0]  cfg_min_sp  = aht_pkg::MIN_SP_RST;
  logic [7:0]  cfg_max_sp  = aht_pkg::MAX_SP_RST;
  logic [7:0]  cfg_init_sp = aht_pkg::INIT_SP_RST;
  logic [7:0]  cfg_step    = aht_pkg::STEP_RST;
  logic [7:0]  cfg_hyst    = aht_pkg::HYST_RST;
  logic [15:0] cfg_blink   = aht_pkg::BLINK_RST;
  logic [15:0] cfg_timeout = aht_pkg::TIMEOUT_RST;

  // Thermostat state as the block should hold it.
  aht_pkg::mode_e mode_now = aht_pkg::MODE_OFF;
  logic [7:0]     samples [RING_LEN];
  logic [2:0]     wr_pos = '0;
  int             sample_sum = 0;
  logic [15:0]    ticks_seen = '0;
  logic [7:0]     target = aht_pkg::INIT_SP_RST;
  logic           up_latched = 1'b0;
  logic           down_latched = 1'b0;
  logic           power_was_down = 1'b0;

  reading_t readings_due[$];
  reading_t got_rd, want_rd;
  int       errors = 0;
  int       readings_checked = 0;
  int       src_idle_pct = 16;
  int       snk_idle_pct = 16;

  initial begin
    foreach (samples[i]) samples[i] = '0;
  end

  function automatic reading_t thermostat_next(input pass_t p);
    int          avg;
    int          sp_i;
    int unsigned div;
    logic        phase;
    reading_t    r;
    if (p.tick && mode_now != aht_pkg::MODE_OFF) begin
      sample_sum = sample_sum - int'(samples[wr_pos]) + int'(p.sample);
      samples[wr_pos] = p.sample;
      wr_pos = wr_pos + 3'd1;
      ticks_seen = ticks_seen + 16'd1;
    end
    case (mode_now)
      aht_pkg::MODE_ON: begin
        if ((p.up && !up_latched) || (p.down && !down_latched)) begin
          ticks_seen = '0;
          mode_now = aht_pkg::MODE_SET;
        end
      end
      aht_pkg::MODE_SET: begin
        if (p.up && !up_latched && int'(target) + int'(cfg_step) <= int'(cfg_max_sp)) begin
          target = target + cfg_step;
          ticks_seen = '0;
          up_latched = 1'b1;
        end
        if (p.down && !down_latched && int'(target) >= int'(cfg_min_sp) + int'(cfg_step)) begin
          target = target - cfg_step;
          ticks_seen = '0;
          down_latched = 1'b1;
        end
        if (ticks_seen >= cfg_timeout) mode_now = aht_pkg::MODE_ON;
      end
      default: ;
    endcase
    if (!p.up) up_latched = 1'b0;
    if (!p.down) down_latched = 1'b0;
    // The key toggles power on its release; turning on starts with an empty ring.
    if (power_was_down && !p.power) begin
      if (mode_now == aht_pkg::MODE_OFF) begin
        foreach (samples[i]) samples[i] = '0;
        wr_pos = '0;
        sample_sum = 0;
        ticks_seen = '0;
        mode_now = aht_pkg::MODE_ON;
      end else begin
        mode_now = aht_pkg::MODE_OFF;
      end
    end
    power_was_down = p.power;

    avg = sample_sum / RING_LEN;
    div = (cfg_blink == 16'd0) ? 1 : int'(cfg_blink);
    phase = ((int'(ticks_seen) / div) % 2) != 0;
    r = '0;
    r.mode = mode_now;
    r.mean = 8'(avg);
    r.setpoint = target;
    if (mode_now != aht_pkg::MODE_OFF) begin
      sp_i = int'(target);
      if (avg < sp_i - int'(cfg_hyst)) begin
        r.heat = 1'b1;
        r.led = phase;
      end else if (avg > sp_i + int'(cfg_hyst)) begin
        r.cool = 1'b1;
        r.led = 1'b1;
      end
      if (mode_now == aht_pkg::MODE_ON) begin
        r.disp = 1'b1;
        r.dval = 8'(avg);
      end else begin
        r.disp = phase;
        r.dval = target;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns: result %0d: %s", $time, readings_checked, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_rd = m_axis_tdata[29:0];
      if (readings_due.size() == 0) begin
        report_mismatch("result transfer with no expected reading");
      end else begin
        want_rd = readings_due.pop_front();
        check_field("mode", 8'(got_rd.mode), 8'(want_rd.mode));
        check_field("heater_on", 8'(got_rd.heat), 8'(want_rd.heat));
        check_field("cooler_on", 8'(got_rd.cool), 8'(want_rd.cool));
        check_field("led_on", 8'(got_rd.led), 8'(want_rd.led));
        check_field("display_on", 8'(got_rd.disp), 8'(want_rd.disp));
        check_field("display_value", got_rd.dval, want_rd.dval);
        check_field("mean_temp", got_rd.mean, want_rd.mean);
        check_field("setpoint", got_rd.setpoint, want_rd.setpoint);
      end
      readings_checked++;
    end
  end

  function automatic pass_t make_pass(input logic tick, input logic [7:0] sample,
                                      input logic up, input logic down, input logic power);
    pass_t p;
    p.tick = tick;
    p.sample = sample;
    p.up = up;
    p.down = down;
    p.power = power;
    return p;
  endfunction

  // Mostly samples around the setpoint so that the mean wanders across the band edges.
  function automatic logic [7:0] pick_sample();
    int r;
    int spread;
    int v;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'hFF;
    if (r < 40) return 8'($urandom());
    spread = int'(cfg_hyst) + 4;
    v = int'(target) - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic send_pass(input pass_t p);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < src_idle_pct) gap = $urandom_range(1, 60);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0000, p};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    readings_due.push_back(thermostat_next(p));
  endtask

  // Registers change only once every result is out and the divider has settled.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (48) @(posedge clk_i);
  endtask

  task automatic write_reg(input aht_pkg::cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      aht_pkg::CFG_MIN_SP:  cfg_min_sp = value[7:0];
      aht_pkg::CFG_MAX_SP:  cfg_max_sp = value[7:0];
      aht_pkg::CFG_INIT_SP: begin
        cfg_init_sp = value[7:0];
        target = value[7:0];
      end
      aht_pkg::CFG_STEP:    cfg_step = value[7:0];
      aht_pkg::CFG_HYST:    cfg_hyst = value[7:0];
      aht_pkg::CFG_BLINK:   cfg_blink = value;
      aht_pkg::CFG_TIMEOUT: cfg_timeout = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] min_sp, input logic [7:0] max_sp,
                                input logic [7:0] init_sp, input logic [7:0] step,
                                input logic [7:0] hyst, input logic [15:0] blink,
                                input logic [15:0] timeout);
    wait_idle();
    write_reg(aht_pkg::CFG_MIN_SP, {8'h00, min_sp});
    write_reg(aht_pkg::CFG_MAX_SP, {8'h00, max_sp});
    write_reg(aht_pkg::CFG_INIT_SP, {8'h00, init_sp});
    write_reg(aht_pkg::CFG_STEP, {8'h00, step});
    write_reg(aht_pkg::CFG_HYST, {8'h00, hyst});
    write_reg(aht_pkg::CFG_BLINK, blink);
    write_reg(aht_pkg::CFG_TIMEOUT, timeout);
  endtask

  task automatic test_off_ignores_ticks();
    send_pass(make_pass(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0));
    send_pass(make_pass(1'b1, 8'h00, 1'b0, 1'b0, 1'b0));
    send_pass(make_pass(1'b0, 8'hAA, 1'b1, 1'b1, 1'b0));
  endtask

  // The release pass also carries a tick, which must be dropped since the block is still off.
  task automatic test_power_on();
    send_pass(make_pass(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
    send_pass(make_pass(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0));
  endtask

  // Three hot samples walk the mean from below the band, through it, to above it.
  task automatic test_band_edges();
    repeat (3) send_pass(make_pass(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_setpoint_keys();
    send_pass(make_pass(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
    send_pass(make_pass(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
    send_pass(make_pass(1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
    send_pass(make_pass(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
    send_pass(make_pass(1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
  endtask

  task automatic test_power_off();
    send_pass(make_pass(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
    send_pass(make_pass(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
  endtask

  // A setpoint of zero with the widest band puts the lower bound below zero.
  task automatic test_extreme_settings();
    apply_settings(8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    send_pass(make_pass(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
    send_pass(make_pass(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0));
    send_pass(make_pass(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
    send_pass(make_pass(1'b1, 8'hFF, 1'b1, 1'b0, 1'b0));
    send_pass(make_pass(1'b1, 8'h00, 1'b1, 1'b1, 1'b0));
  endtask

  // Zero step, zero blink period and zero timeout.
  task automatic test_zero_settings();
    apply_settings(8'd0, 8'd255, 8'd128, 8'd0, 8'd0, 16'd0, 16'd0);
    send_pass(make_pass(1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
    send_pass(make_pass(1'b1, 8'hFF, 1'b1, 1'b0, 1'b0));
    send_pass(make_pass(1'b1, 8'h00, 1'b0, 1'b0, 1'b0));
    send_pass(make_pass(1'b1, 8'h00, 1'b0, 1'b1, 1'b0));
  endtask

  task automatic random_settings();
    int lo;
    int hi;
    int t;
    int step;
    int hyst;
    int blink;
    int timeout;
    lo = $urandom_range(0, 150);
    hi = $urandom_range(lo, 255);
    if ($urandom_range(0, 9) == 0) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 15);
    hyst = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
    blink = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 8);
    timeout = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 25);
    apply_settings(8'(lo), 8'(hi), 8'($urandom_range(lo, hi)), 8'(step), 8'(hyst),
                   16'(blink), 16'(timeout));
  endtask

  // Key presses are held for a few passes and then released; power goes back on soon after off.
  task automatic run_random_phase(input int n_items);
    int          sent;
    int          r;
    int          hold;
    int          which;
    logic [11:0] raw;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if ((mode_now == aht_pkg::MODE_OFF && r < 60) || r < 5) begin
        hold = $urandom_range(1, 3);
        repeat (hold) begin
          send_pass(make_pass(1'($urandom_range(0, 1)), pick_sample(), 1'b0, 1'b0, 1'b1));
        end
        send_pass(make_pass(1'($urandom_range(0, 1)), pick_sample(), 1'b0, 1'b0, 1'b0));
        sent += hold + 1;
      end else if (r < 30) begin
        which = $urandom_range(0, 2);
        hold = $urandom_range(1, 4);
        repeat (hold) begin
          send_pass(make_pass(1'($urandom_range(0, 1)), pick_sample(), which != 1, which != 0,
                              1'b0));
        end
        send_pass(make_pass(1'($urandom_range(0, 1)), pick_sample(), 1'b0, 1'b0, 1'b0));
        sent += hold + 1;
      end else if (r < 36) begin
        raw = 12'($urandom());
        send_pass(raw);
        sent++;
      end else begin
        send_pass(make_pass($urandom_range(0, 99) < 85, pick_sample(), 1'b0, 1'b0, 1'b0));
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 10; ph++) begin
      random_settings();
      src_idle_pct = (ph == 4) ? 0 : 16;
      snk_idle_pct = (ph == 4) ? 0 : 16;
      run_random_phase(155);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_off_ignores_ticks();
    test_power_on();
    test_band_edges();
    test_setpoint_keys();
    test_power_off();
    test_extreme_settings();
    test_zero_settings();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("PASS averaging_hysteresis_thermostat_unit");
    end else begin
      $display("FAIL averaging_hysteresis_thermostat_unit");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL averaging_hysteresis_thermostat_unit");
    $finish;
  end

endmodule
